/* src/modbus_rtu_gap_framer_macros.svh */
// Assertion helpers for the Modbus RTU gap framer.
// Define ASSERT_OFF to compile them out.
`ifndef MODBUS_RTU_GAP_FRAMER_MACROS_SVH
`define MODBUS_RTU_GAP_FRAMER_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, masked while reset is high.
`define MRGF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mrgf: assertion failed");

// Clocked check that also runs through reset.
`define MRGF_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mrgf: assertion failed");

`else

`define MRGF_ASSERT(lbl, clk, rst, prop)
`define MRGF_ASSERT_NR(lbl, clk, prop)

`endif

`endif

/* src/mrgf_pkg.sv */
package mrgf_pkg;

   // item codes
   typedef enum logic [1:0] {
      MODE_BYTE = 2'd0,
      MODE_TICK = 2'd1,
      MODE_READ = 2'd2,
      MODE_TAKE = 2'd3
   } mode_type;

   localparam int unsigned MAX_FRAME_BYTES_DFLT = 256;

   // register map: byte address bits [CSR_AW-1:2] select the register
   localparam int unsigned CSR_AW            = 3;
   localparam logic [0:0]  REG_GAP_THRESHOLD = 1'b0;
   localparam logic [31:0] GAP_THRESHOLD_RST = 32'd4;

   // Modbus CRC-16, reflected
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam int unsigned CRC_MIN_BYTES = 4;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* src/mrgf_req_if.sv */
interface mrgf_req_if;
   logic                valid;
   logic                ready;
   mrgf_pkg::mode_type  mode;
   logic [7:0]          data_byte;
   logic [31:0]         time_ms;
   logic [7:0]          read_index;

   modport source (output valid, mode, data_byte, time_ms, read_index, input ready);
   modport sink   (input valid, mode, data_byte, time_ms, read_index, output ready);
endinterface

/* src/mrgf_rsp_if.sv */
interface mrgf_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ready;
   logic [8:0]  frame_length;
   logic        crc_ok;
   logic [31:0] frame_start_ms;
   logic [7:0]  read_data;
   logic        frame_closed;
   logic        frame_dropped;

   modport source (output valid, frame_ready, frame_length, crc_ok, frame_start_ms,
                   read_data, frame_closed, frame_dropped, input ready);
   modport sink   (input valid, frame_ready, frame_length, crc_ok, frame_start_ms,
                   read_data, frame_closed, frame_dropped, output ready);
endinterface

/* src/modbus_rtu_gap_framer.sv */
// Each accepted req beat has its rsp beat registered for the next cycle.
// Throughput: one item per cycle while rsp keeps up; the byte memory takes
// one write and one registered read per cycle; all per-frame state is in flops.
// Reset (synchronous, active high) clears counts, flags, CRC, bank pointer and
// threshold (to 4 ms) at once; the byte memory is not cleared and needs no pass.
`include "modbus_rtu_gap_framer_macros.svh"

module modbus_rtu_gap_framer #(
   parameter int unsigned MAX_FRAME_BYTES = mrgf_pkg::MAX_FRAME_BYTES_DFLT
) (
   input  logic                        clock,
   input  logic                        reset,
   mrgf_req_if.sink                    req_chan,
   mrgf_rsp_if.source                  rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mrgf_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   // CW holds a count up to MAX_FRAME_BYTES, AW indexes one bank
   localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);
   localparam int unsigned XW = CW + 8;   // common width for index compares

   // ------------------------------------------------------------------
   // Byte memory: two banks, each MAX_FRAME_BYTES rounded up to a power
   // of two. One bank collects, the other holds the pending frame.
   // Closing a frame into a free slot just flips the bank pointer, so
   // there is no copy.
   // ------------------------------------------------------------------
   logic [7:0] mem [2**(AW+1)];
   logic [7:0] rd_data_ff;

   // CSR
   logic [31:0] gap_thr_ff;
   logic        csr_sel_gap;
   logic        csr_wr;

   // collector state
   logic [CW-1:0] col_cnt_ff,   col_cnt_in;
   logic [15:0]   crc_ff,       crc_in;
   logic [31:0]   col_start_ff, col_start_in;
   logic [31:0]   last_byte_ff, last_byte_in;
   logic          seen_ff,      seen_in;

   // pending slot
   logic          pend_bank_ff,  pend_bank_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [CW-1:0] pend_cnt_ff,   pend_cnt_in;
   logic          pend_ok_ff,    pend_ok_in;
   logic [31:0]   pend_start_ff, pend_start_in;

   // result register (one beat deep; read data joins from the memory register)
   logic          rsp_valid_ff;
   logic          rsp_frame_ff,  rsp_frame_in;
   logic [8:0]    rsp_len_ff,    rsp_len_in;
   logic          rsp_ok_ff,     rsp_ok_in;
   logic [31:0]   rsp_start_ff,  rsp_start_in;
   logic          rsp_rd_ff;
   logic          rsp_closed_ff;
   logic          rsp_drop_ff;

   // datapath
   mrgf_pkg::mode_type mode;
   logic          acc;
   logic          time_item;
   logic [31:0]   elapsed;
   logic          gap_close;
   logic          gap_drop;
   logic          gap_move;
   logic [CW-1:0] cnt_after;
   logic          restart;
   logic [CW-1:0] wr_pos;
   logic          col_bank;
   logic [15:0]   crc_seed;
   logic [XW-1:0] idx_ext;
   logic [XW-1:0] pend_cnt_ext;
   logic [XW-1:0] rep_cnt_ext;
   logic          rd_hit;
   logic          move_ok;
   logic          wr_en;

   // ------------------------------------------------------------------
   // APB register port: no wait states, one register
   // ------------------------------------------------------------------
   assign csr_pready  = 1'b1;
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel_gap = (csr_paddr[mrgf_pkg::CSR_AW-1:2] == mrgf_pkg::REG_GAP_THRESHOLD);
   assign csr_prdata  = csr_sel_gap ? gap_thr_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_thr_ff <= mrgf_pkg::GAP_THRESHOLD_RST;
      end else if (csr_wr && csr_sel_gap) begin
         gap_thr_ff <= csr_pwdata;
      end
   end

   // ------------------------------------------------------------------
   // Handshake: the result register frees as it is taken, so a new beat
   // comes in every cycle while the sink keeps up.
   // ------------------------------------------------------------------
   assign mode           = req_chan.mode;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign acc            = req_chan.valid && req_chan.ready;

   // ------------------------------------------------------------------
   // Gap check: wrapping 32-bit elapsed time against the threshold
   // ------------------------------------------------------------------
   assign time_item = (mode == mrgf_pkg::MODE_BYTE) || (mode == mrgf_pkg::MODE_TICK);
   assign elapsed   = req_chan.time_ms - last_byte_ff;
   assign gap_close = time_item && seen_ff && (col_cnt_ff != '0) && (elapsed >= gap_thr_ff);
   assign gap_drop  = gap_close && pend_valid_ff;
   assign gap_move  = gap_close && !pend_valid_ff;
   assign move_ok   = (col_cnt_ff >= CW'(mrgf_pkg::CRC_MIN_BYTES)) && (crc_ff == 16'd0);

   // collecting bank after a possible flip
   assign col_bank  = gap_move ? pend_bank_ff : !pend_bank_ff;

   // byte placement: empty or full buffer restarts the frame
   assign cnt_after = gap_close ? '0 : col_cnt_ff;
   assign restart   = (cnt_after == '0) || (cnt_after >= CW'(MAX_FRAME_BYTES));
   assign wr_pos    = restart ? '0 : cnt_after;
   assign crc_seed  = restart ? mrgf_pkg::CRC_INIT : crc_ff;
   assign wr_en     = acc && (mode == mrgf_pkg::MODE_BYTE);

   // pending-byte read
   assign idx_ext      = XW'(req_chan.read_index);
   assign pend_cnt_ext = XW'(pend_cnt_ff);
   assign rd_hit       = (mode == mrgf_pkg::MODE_READ) && pend_valid_ff
                         && (idx_ext < pend_cnt_ext);

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      col_cnt_in    = col_cnt_ff;
      crc_in        = crc_ff;
      col_start_in  = col_start_ff;
      last_byte_in  = last_byte_ff;
      seen_in       = seen_ff;
      pend_bank_in  = pend_bank_ff;
      pend_valid_in = pend_valid_ff;
      pend_cnt_in   = pend_cnt_ff;
      pend_ok_in    = pend_ok_ff;
      pend_start_in = pend_start_ff;

      if (gap_move) begin
         pend_bank_in  = !pend_bank_ff;
         pend_valid_in = 1'b1;
         pend_cnt_in   = col_cnt_ff;
         pend_ok_in    = move_ok;
         pend_start_in = col_start_ff;
      end
      if (gap_close) begin
         col_cnt_in = '0;
      end

      unique case (mode)
         mrgf_pkg::MODE_BYTE: begin
            col_cnt_in   = wr_pos + CW'(1);
            crc_in       = mrgf_pkg::crc16_update(crc_seed, req_chan.data_byte);
            col_start_in = restart ? req_chan.time_ms : col_start_ff;
            last_byte_in = req_chan.time_ms;
            seen_in      = 1'b1;
         end
         mrgf_pkg::MODE_TICK: begin
         end
         mrgf_pkg::MODE_READ: begin
         end
         mrgf_pkg::MODE_TAKE: begin
            pend_valid_in = 1'b0;
            pend_cnt_in   = '0;
            pend_ok_in    = 1'b0;
            pend_start_in = 32'd0;
         end
      endcase
   end

   // reported slot: after any close, before any take
   assign rep_cnt_ext = gap_move ? XW'(col_cnt_ff) : pend_cnt_ext;

   always_comb begin
      rsp_frame_in = pend_valid_ff || gap_move;
      rsp_len_in   = rsp_frame_in ? rep_cnt_ext[8:0] : 9'd0;
      rsp_ok_in    = gap_move ? move_ok : (pend_valid_ff && pend_ok_ff);
      rsp_start_in = gap_move ? col_start_ff : (pend_valid_ff ? pend_start_ff : 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff    <= '0;
         crc_ff        <= mrgf_pkg::CRC_INIT;
         col_start_ff  <= 32'd0;
         last_byte_ff  <= 32'd0;
         seen_ff       <= 1'b0;
         pend_bank_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_cnt_ff   <= '0;
         pend_ok_ff    <= 1'b0;
         pend_start_ff <= 32'd0;
      end else if (acc) begin
         col_cnt_ff    <= col_cnt_in;
         crc_ff        <= crc_in;
         col_start_ff  <= col_start_in;
         last_byte_ff  <= last_byte_in;
         seen_ff       <= seen_in;
         pend_bank_ff  <= pend_bank_in;
         pend_valid_ff <= pend_valid_in;
         pend_cnt_ff   <= pend_cnt_in;
         pend_ok_ff    <= pend_ok_in;
         pend_start_ff <= pend_start_in;
      end
   end

   // byte memory: collect bank written, pending bank read, never the same bank
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{col_bank, wr_pos[AW-1:0]}] <= req_chan.data_byte;
      end
      if (acc && rd_hit) begin
         rd_data_ff <= mem[{pend_bank_ff, idx_ext[AW-1:0]}];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         rsp_frame_ff  <= rsp_frame_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_ok_ff     <= rsp_ok_in;
         rsp_start_ff  <= rsp_start_in;
         rsp_rd_ff     <= rd_hit;
         rsp_closed_ff <= gap_close;
         rsp_drop_ff   <= gap_drop;
      end
   end

   // rd_data_ff only moves on accept, so it holds with the beat while stalled
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.frame_ready    = rsp_frame_ff;
   assign rsp_chan.frame_length   = rsp_len_ff;
   assign rsp_chan.crc_ok         = rsp_ok_ff;
   assign rsp_chan.frame_start_ms = rsp_start_ff;
   assign rsp_chan.read_data      = rsp_rd_ff ? rd_data_ff : 8'd0;
   assign rsp_chan.frame_closed   = rsp_closed_ff;
   assign rsp_chan.frame_dropped  = rsp_drop_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `MRGF_ASSERT(a_cnt_bound, clock, reset, col_cnt_ff <= CW'(MAX_FRAME_BYTES))
   `MRGF_ASSERT(a_pend_nonempty, clock, reset, pend_valid_ff |-> (pend_cnt_ff != '0))
   `MRGF_ASSERT(a_take_clears, clock, reset,
                (acc && (mode == mrgf_pkg::MODE_TAKE)) |=> !pend_valid_ff)
   `MRGF_ASSERT(a_drop_full, clock, reset,
                (rsp_valid_ff && rsp_drop_ff) |-> (rsp_closed_ff && rsp_frame_ff))
   `MRGF_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid_ff)

endmodule

/* tb/sv/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAME_MAX = mrgf_pkg::MAX_FRAME_BYTES_DFLT;
   localparam logic [15:0] CRC_SEED  = 16'hFFFF;
   localparam logic [15:0] CRC_REFL  = 16'hA001;

   // one input beat
   typedef struct packed {
      mrgf_pkg::mode_type mode;
      logic [7:0]         data_byte;
      logic [31:0]        time_ms;
      logic [7:0]         read_index;
   } req_item_type;

   // one result beat, field order as on the rsp channel
   typedef struct packed {
      logic        frame_ready;
      logic [8:0]  frame_length;
      logic        crc_ok;
      logic [31:0] frame_start_ms;
      logic [7:0]  read_data;
      logic        frame_closed;
      logic        frame_dropped;
   } rsp_type;

   // directed row: typed = 1 means the result is written out by hand
   typedef struct packed {
      req_item_type item;
      logic         typed;
      rsp_type      want;
   } dir_row_type;

   localparam rsp_type RSP_IDLE = '0;
   // the 8-byte request frame, still pending, as seen by a take
   localparam rsp_type RSP_REQ8 = '{1'b1, 9'd8, 1'b1, 32'd100, 8'h00, 1'b0, 1'b0};

   // Directed run at the reset threshold of 4 ms:
   //  - empty block: tick, take, reads at both index extremes give all zeros
   //  - a valid read-holding-register request closed by a tick, one short of
   //    the gap first, then exactly on it
   //  - reads inside and just past the pending frame
   //  - a two-byte frame whose residue is zero but is too short to pass,
   //    with its timestamps wrapping through 2^32
   //  - a frame closed while the slot is full, so it is dropped
   //  - take and read once the slot is empty again
   localparam dir_row_type DIRECTED_TAB [25] = '{
      '{'{mrgf_pkg::MODE_TICK, 8'h00, 32'd0,          8'h00}, 1'b1, RSP_IDLE},
      '{'{mrgf_pkg::MODE_TAKE, 8'hFF, 32'hFFFF_FFFF,  8'hFF}, 1'b1, RSP_IDLE},
      '{'{mrgf_pkg::MODE_READ, 8'h00, 32'd0,          8'h00}, 1'b1, RSP_IDLE},
      '{'{mrgf_pkg::MODE_READ, 8'h00, 32'd0,          8'hFF}, 1'b1, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'h01, 32'd100,        8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'h03, 32'd101,        8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'h00, 32'd102,        8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'h00, 32'd103,        8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'h00, 32'd104,        8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'h01, 32'd105,        8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'h84, 32'd106,        8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'h0A, 32'd107,        8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_TICK, 8'h00, 32'd110,        8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_TICK, 8'h00, 32'd111,        8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_READ, 8'h00, 32'd0,          8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_READ, 8'h00, 32'd0,          8'h07}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_READ, 8'h00, 32'd0,          8'h08}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_TAKE, 8'h00, 32'd0,          8'h00}, 1'b1, RSP_REQ8},
      '{'{mrgf_pkg::MODE_BYTE, 8'hFF, 32'hFFFF_FFFF,  8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'hFF, 32'd2,          8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_TICK, 8'h00, 32'd6,          8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'h00, 32'd7,          8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_BYTE, 8'h55, 32'd11,         8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_TAKE, 8'h00, 32'd0,          8'h00}, 1'b0, RSP_IDLE},
      '{'{mrgf_pkg::MODE_READ, 8'h00, 32'd0,          8'h00}, 1'b1, RSP_IDLE}
   };

   logic                        clock;
   logic                        reset;
   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [mrgf_pkg::CSR_AW-1:0] csr_paddr;
   logic [31:0]                 csr_pwdata;
   logic [31:0]                 csr_prdata;
   logic                        csr_pready;

   mrgf_req_if req_bus ();
   mrgf_rsp_if rsp_bus ();

   modbus_rtu_gap_framer #(
      .MAX_FRAME_BYTES (FRAME_MAX)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------------
   // Framer state as the testbench sees it
   // ---------------------------------------------------------------------
   logic [31:0] thr_ms;          // gap threshold currently programmed
   logic [7:0]  col_buf [FRAME_MAX];
   int unsigned col_len;
   logic [15:0] col_crc;
   logic [31:0] col_start;
   logic [31:0] last_rx_ms;
   logic        any_rx;
   logic [7:0]  pend_buf [FRAME_MAX];
   int unsigned pend_len;
   logic        pend_valid;
   logic        pend_crc_good;
   logic [31:0] pend_start;

   rsp_type     due_results_q [$];   // predicted beats, oldest first
   int unsigned error_count;
   int unsigned items_sent;
   logic        req_busy;            // sender draws gaps when set
   logic        rsp_busy;            // receiver draws stalls when set
   logic [31:0] now_ms;              // running serial clock for stimulus

   // Modbus CRC-16, one bit at a time, LSB first
   function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = c >> 1;
         if (fb)
            c = c ^ CRC_REFL;
      end
      return c;
   endfunction

   function automatic void framer_clear();
      thr_ms        = mrgf_pkg::GAP_THRESHOLD_RST;
      col_len       = 0;
      col_crc       = CRC_SEED;
      col_start     = '0;
      last_rx_ms    = '0;
      any_rx        = 1'b0;
      pend_len      = 0;
      pend_valid    = 1'b0;
      pend_crc_good = 1'b0;
      pend_start    = '0;
   endfunction

   // silence check made before a byte is stored and on every tick
   function automatic void close_on_gap(logic [31:0] now, output logic closed,
                                        output logic dropped);
      logic [31:0] since;
      closed  = 1'b0;
      dropped = 1'b0;
      since   = now - last_rx_ms;
      if (!any_rx || col_len == 0 || since < thr_ms)
         return;
      closed = 1'b1;
      if (pend_valid) begin
         dropped = 1'b1;
      end else begin
         for (int unsigned i = 0; i < col_len; i++)
            pend_buf[i] = col_buf[i];
         pend_len      = col_len;
         pend_crc_good = (col_len >= 4) && (col_crc == 16'h0000);
         pend_start    = col_start;
         pend_valid    = 1'b1;
      end
      col_len = 0;
   endfunction

   function automatic rsp_type framer_predict(req_item_type it);
      rsp_type r;
      logic    closed;
      logic    dropped;
      r       = '0;
      closed  = 1'b0;
      dropped = 1'b0;
      if (it.mode == mrgf_pkg::MODE_BYTE || it.mode == mrgf_pkg::MODE_TICK)
         close_on_gap(it.time_ms, closed, dropped);
      if (it.mode == mrgf_pkg::MODE_BYTE) begin
         // empty or full buffer: start afresh with this byte
         if (col_len == 0 || col_len >= FRAME_MAX) begin
            col_len   = 0;
            col_start = it.time_ms;
            col_crc   = CRC_SEED;
         end
         col_buf[col_len] = it.data_byte;
         col_len++;
         col_crc    = crc16_fold(col_crc, it.data_byte);
         last_rx_ms = it.time_ms;
         any_rx     = 1'b1;
      end
      if (it.mode == mrgf_pkg::MODE_READ && pend_valid && it.read_index < pend_len)
         r.read_data = pend_buf[it.read_index];
      r.frame_ready = pend_valid;
      if (pend_valid) begin
         r.frame_length   = pend_len[8:0];
         r.crc_ok         = pend_crc_good;
         r.frame_start_ms = pend_start;
      end
      r.frame_closed  = closed;
      r.frame_dropped = dropped;
      // a take reports the slot as it was, then frees it
      if (it.mode == mrgf_pkg::MODE_TAKE) begin
         pend_valid    = 1'b0;
         pend_len      = 0;
         pend_crc_good = 1'b0;
         pend_start    = '0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, time limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Inputs move on the falling edge. This task lowers valid only when a gap is
   // drawn, so back-to-back beats never see a low/high pair in one step.
   task automatic send_item(input req_item_type it, input logic typed = 1'b0,
                            input rsp_type fixed = '0);
      int unsigned gap;
      rsp_type     guess;
      gap = req_busy ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= it.mode;
      req_bus.data_byte  <= it.data_byte;
      req_bus.time_ms    <= it.time_ms;
      req_bus.read_index <= it.read_index;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      guess = framer_predict(it);
      due_results_q.push_back(typed ? fixed : guess);
      items_sent++;
   endtask

   // drop valid and wait for every outstanding beat to come back
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (due_results_q.size() != 0)
         @(posedge clock);
   endtask

   // APB write, setup then access; only called with the framer drained
   task automatic set_gap_threshold(input logic [31:0] value);
      settle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= mrgf_pkg::CSR_AW'({mrgf_pkg::REG_GAP_THRESHOLD, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      thr_ms = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // spacing that keeps a frame open; now and then exactly one short
   function automatic logic [31:0] quiet_delta();
      if (thr_ms == 0)
         return '0;
      if ($urandom_range(0, 7) == 0)
         return thr_ms - 1;
      return (thr_ms > 4) ? $urandom_range(0, 3) : $urandom_range(0, thr_ms - 1);
   endfunction

   // spacing that closes a frame: threshold plus a little, no wrap past 2^32
   function automatic logic [31:0] gap_delta();
      logic [31:0] spare;
      spare = ~thr_ms;
      return thr_ms + ((spare < 3) ? $urandom_range(0, spare) : $urandom_range(0, 3));
   endfunction

   // one frame; with good_crc the last two bytes are the CRC, low first
   task automatic send_frame(input int unsigned len, input logic good_crc);
      req_item_type it;
      logic [15:0]  crc;
      logic [15:0]  tail;
      crc  = CRC_SEED;
      tail = '0;
      for (int unsigned i = 0; i < len; i++) begin
         it.mode       = mrgf_pkg::MODE_BYTE;
         it.read_index = 8'($urandom);
         if (good_crc && len >= 2 && i == len - 2) begin
            tail         = crc;
            it.data_byte = tail[7:0];
         end else if (good_crc && len >= 2 && i == len - 1) begin
            it.data_byte = tail[15:8];
         end else begin
            it.data_byte = 8'($urandom);
            crc          = crc16_fold(crc, it.data_byte);
         end
         now_ms     = now_ms + ((i == 0) ? gap_delta() : quiet_delta());
         it.time_ms = now_ms;
         send_item(it);
      end
   endtask

   // Random phase: mostly well-formed frames with random content, each
   // optionally closed by a tick, read back in part and usually taken.
   // The rest is noise: random beats and ticks that land mid-frame.
   task automatic run_phase(input logic [31:0] thr, input int unsigned n_items,
                            input int unsigned first_len);
      int unsigned  start_cnt;
      int unsigned  len;
      int unsigned  pick;
      int unsigned  top;
      req_item_type it;
      set_gap_threshold(thr);
      now_ms    = $urandom;
      start_cnt = items_sent;
      while (items_sent - start_cnt < n_items) begin
         req_busy = ($urandom_range(0, 3) != 0);
         rsp_busy = ($urandom_range(0, 3) != 0);
         pick     = $urandom_range(0, 15);
         if (pick == 0) begin
            it.mode       = mrgf_pkg::mode_type'($urandom_range(0, 3));
            it.data_byte  = 8'($urandom);
            it.time_ms    = $urandom;
            it.read_index = 8'($urandom);
            if (it.mode == mrgf_pkg::MODE_BYTE)
               now_ms = it.time_ms;
            send_item(it);
         end else if (pick == 1) begin
            // tick inside a frame: must not close it
            it.mode       = mrgf_pkg::MODE_TICK;
            it.data_byte  = 8'($urandom);
            it.time_ms    = now_ms + quiet_delta();
            it.read_index = 8'($urandom);
            send_item(it);
         end else begin
            if (first_len != 0)
               len = first_len;
            else
               len = $urandom_range(1, 12);
            first_len = 0;
            send_frame(len, $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0) begin
               it.mode       = mrgf_pkg::MODE_TICK;
               it.data_byte  = 8'($urandom);
               it.time_ms    = now_ms + gap_delta();
               it.read_index = 8'($urandom);
               send_item(it);
            end
            top = (len > 255) ? 255 : len;
            repeat ($urandom_range(0, 3)) begin
               it.mode       = mrgf_pkg::MODE_READ;
               it.data_byte  = 8'($urandom);
               it.time_ms    = $urandom;
               it.read_index = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, top))
                                                           : 8'($urandom);
               send_item(it);
            end
            // leaving the slot full now and then makes later frames drop
            if ($urandom_range(0, 3) != 0) begin
               it.mode       = mrgf_pkg::MODE_TAKE;
               it.data_byte  = 8'($urandom);
               it.time_ms    = $urandom;
               it.read_index = 8'($urandom);
               send_item(it);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: stalls drawn per beat, checked on the rising edge
   // ---------------------------------------------------------------------
   initial begin
      int unsigned stall;
      forever begin
         stall = rsp_busy ? $urandom_range(0, 3) : 0;
         @(negedge clock);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (due_results_q.size() == 0) begin
            $error("rsp beat with nothing outstanding");
            error_count++;
         end else begin
            want = due_results_q.pop_front();
            if (rsp_bus.frame_ready !== want.frame_ready) begin
               $error("frame_ready: expected %0d, got %0d",
                      want.frame_ready, rsp_bus.frame_ready);
               error_count++;
            end
            if (rsp_bus.frame_length !== want.frame_length) begin
               $error("frame_length: expected %0d, got %0d",
                      want.frame_length, rsp_bus.frame_length);
               error_count++;
            end
            if (rsp_bus.crc_ok !== want.crc_ok) begin
               $error("crc_ok: expected %0d, got %0d", want.crc_ok, rsp_bus.crc_ok);
               error_count++;
            end
            if (rsp_bus.frame_start_ms !== want.frame_start_ms) begin
               $error("frame_start_ms: expected %0h, got %0h",
                      want.frame_start_ms, rsp_bus.frame_start_ms);
               error_count++;
            end
            if (rsp_bus.read_data !== want.read_data) begin
               $error("read_data: expected %0h, got %0h",
                      want.read_data, rsp_bus.read_data);
               error_count++;
            end
            if (rsp_bus.frame_closed !== want.frame_closed) begin
               $error("frame_closed: expected %0d, got %0d",
                      want.frame_closed, rsp_bus.frame_closed);
               error_count++;
            end
            if (rsp_bus.frame_dropped !== want.frame_dropped) begin
               $error("frame_dropped: expected %0d, got %0d",
                      want.frame_dropped, rsp_bus.frame_dropped);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_bus.valid      = 1'b0;
      req_bus.mode       = mrgf_pkg::MODE_BYTE;
      req_bus.data_byte  = '0;
      req_bus.time_ms    = '0;
      req_bus.read_index = '0;
      rsp_bus.ready      = 1'b0;
      error_count        = 0;
      items_sent         = 0;
      req_busy           = 1'b1;
      rsp_busy           = 1'b1;
      now_ms             = '0;
      framer_clear();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset threshold
      foreach (DIRECTED_TAB[i])
         send_item(DIRECTED_TAB[i].item, DIRECTED_TAB[i].typed, DIRECTED_TAB[i].want);

      // zero threshold: every byte after a collected one closes the frame
      run_phase(32'd0, 20, 0);
      // widest threshold; the first frame overruns the buffer
      run_phase(32'hFFFF_FFFF, 1, 260);
      run_phase(32'd1, 20, 0);
      // first frame fills the buffer exactly, so index 255 is readable
      run_phase(32'd20, 1, 256);
      run_phase(32'h8000_0000, 20, 0);
      run_phase(mrgf_pkg::GAP_THRESHOLD_RST, 20, 0);

      settle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
